### hdl/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request and status codes, default sizing and the control bundles shared
// between the pointer control and the top level.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int VALUE_W       = 64;
   localparam int REQ_W         = 3;
   localparam int STATUS_W      = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_POP_FRONT  = 3'd1,
      REQ_PUSH_BACK  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_CLEAR      = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      status_type status;
      logic       popped;
      logic       is_empty;
   } result_info_type;

endpackage : deq_pkg
`default_nettype wire

### hdl/deq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot memory
// Single-port synchronous RAM holding the queue values. Read data is
// registered and holds its value between reads.
// ----------------------------------------------------------------------------
module deq_ram
   import deq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire mem_ctl_type        mem_ctl,
   input  wire logic [PTR_W-1:0]   addr,
   input  wire logic [VALUE_W-1:0] wr_data,
   output logic      [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : deq_ram
`default_nettype wire

### hdl/deq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pointer control
// Holds the front and back pointers and the occupancy, decodes each request
// and issues the single slot access it needs.
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH,
   parameter int PTR_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_accept,
   input  wire logic [REQ_W-1:0] req_code,
   output mem_ctl_type           mem_ctl,
   output logic      [PTR_W-1:0] mem_addr,
   output result_info_type       info,
   output logic      [CNT_W-1:0] fill_next
);

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] front_prev, front_next, back_prev, back_next;
   logic             is_full, is_void;
   mem_ctl_type      mem_raw;
   status_type       status;

   assign front_prev = (front_ff == '0) ? LAST_SLOT : front_ff - PTR_W'(1);
   assign front_next = (front_ff == LAST_SLOT) ? '0 : front_ff + PTR_W'(1);
   assign back_prev  = (back_ff == '0) ? LAST_SLOT : back_ff - PTR_W'(1);
   assign back_next  = (back_ff == LAST_SLOT) ? '0 : back_ff + PTR_W'(1);
   assign is_full    = (count_ff == FULL_CNT);
   assign is_void    = (count_ff == '0);

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      mem_raw  = '0;
      mem_addr = front_ff;
      status   = ST_DONE;
      case (req_code_type'(req_code))
         REQ_PUSH_FRONT: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               front_in      = front_prev;
               mem_addr      = front_prev;
               mem_raw.wr_en = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         REQ_POP_FRONT: begin
            if (is_void) begin
               status = ST_EMPTY;
            end else begin
               front_in      = front_next;
               mem_addr      = front_ff;
               mem_raw.rd_en = 1'b1;
               count_in      = count_ff - CNT_W'(1);
            end
         end
         REQ_PUSH_BACK: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               back_in       = back_next;
               mem_addr      = back_ff;
               mem_raw.wr_en = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         REQ_POP_BACK: begin
            if (is_void) begin
               status = ST_EMPTY;
            end else begin
               back_in       = back_prev;
               mem_addr      = back_prev;
               mem_raw.rd_en = 1'b1;
               count_in      = count_ff - CNT_W'(1);
            end
         end
         REQ_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mem_ctl.wr_en = mem_raw.wr_en & req_accept;
      mem_ctl.rd_en = mem_raw.rd_en & req_accept;
      info.status   = status;
      info.popped   = mem_raw.rd_en;
      info.is_empty = (count_in == '0);
      fill_next     = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (req_accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("Occupancy exceeds the queue depth.");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("Slot memory read and written in the same cycle.");

   a_ring_wrap: assert property (@(posedge clock) disable iff (reset)
      (is_void || is_full) |-> (front_ff == back_ff))
      else $error("Pointers disagree with an empty or full queue.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (mem_ctl.wr_en || mem_ctl.rd_en)) |=>
         (count_ff != $past(count_ff)))
      else $error("Slot access without an occupancy change.");
`endif

endmodule : deq_ctrl
`default_nettype wire

### hdl/double_ended_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the result side keeps rsp_ready high.
// The single-port slot RAM with its registered read sets this result timing.
// Reset clears the pointers, the occupancy and the result valid; slot contents
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Ring buffer deque with push and pop at both ends and a clear request.
// ----------------------------------------------------------------------------
module double_ended_queue_top
   import deq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [REQ_W-1:0]    req_type,
   input  wire logic [VALUE_W-1:0]  req_push_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [VALUE_W-1:0]  rsp_pop_value,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [CNT_W-1:0]    rsp_fill_count,
   output logic                     rsp_is_empty
);

   localparam int PTR_W = $clog2(DEPTH);

   logic               req_accept;
   mem_ctl_type        mem_ctl;
   logic [PTR_W-1:0]   mem_addr;
   logic [VALUE_W-1:0] rd_data;
   result_info_type    info;
   logic [CNT_W-1:0]   fill_next;

   logic               out_valid_ff;
   result_info_type    info_ff;
   logic [CNT_W-1:0]   fill_ff;

   assign req_ready  = !out_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   deq_ctrl #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_code   (req_type),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .info       (info),
      .fill_next  (fill_next)
   );

   deq_ram #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .addr    (mem_addr),
      .wr_data (req_push_value),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_ready) begin
         out_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         info_ff <= info;
         fill_ff <= fill_next;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pop_value  = info_ff.popped ? rd_data : '0;
   assign rsp_status     = info_ff.status;
   assign rsp_fill_count = fill_ff;
   assign rsp_is_empty   = info_ff.is_empty;

`ifndef NO_ASSERTIONS
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_fill_count == '0)))
      else $error("Empty flag disagrees with the fill count.");

   a_pop_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && info_ff.popped) |-> (rsp_status == ST_DONE))
      else $error("Popped value reported with a failure status.");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rd_data))
      else $error("Pending result data changed while stalled.");
`endif

endmodule : double_ended_queue_top
`default_nettype wire
